[rtl/core/l2ti_pkg.sv]
// shared types, constants and table for the 2-D Lagrange table interpolator
`timescale 1ns / 1ps
package l2ti_pkg;

  localparam logic [15:0] SEC_LO   = 16'd4096;
  localparam logic [15:0] SEC_HI   = 16'd8192;
  localparam logic [15:0] SEC_STEP = 16'd1024;
  localparam logic [15:0] TMP_LO   = 16'd12160;
  localparam logic [15:0] TMP_HI   = 16'd19840;
  localparam logic [15:0] TMP_STEP = 16'd640;

  localparam int NROW = 5;
  localparam int NCOL = 13;

  localparam logic [13:0] GRID_MIL [0:NROW-1][0:NCOL-1] = '{
    '{14'd559, 14'd424, 14'd286, 14'd137, 14'd123, 14'd198, 14'd333, 14'd696, 14'd1217,
      14'd3184, 14'd5178, 14'd8269, 14'd12452},
    '{14'd542, 14'd416, 14'd294, 14'd162, 14'd156, 14'd240, 14'd366, 14'd704, 14'd1184,
      14'd2926, 14'd4854, 14'd7885, 14'd11985},
    '{14'd520, 14'd405, 14'd305, 14'd194, 14'd199, 14'd294, 14'd409, 14'd715, 14'd1141,
      14'd2591, 14'd4433, 14'd7389, 14'd11381},
    '{14'd491, 14'd391, 14'd319, 14'd238, 14'd257, 14'd367, 14'd467, 14'd729, 14'd1083,
      14'd2140, 14'd3866, 14'd6720, 14'd10567},
    '{14'd450, 14'd370, 14'd340, 14'd300, 14'd340, 14'd470, 14'd550, 14'd750, 14'd1000,
      14'd1500, 14'd3060, 14'd5770, 14'd9410}
  };

  // rounding and scaling: r = round(num / (K * 2^SH))
  localparam logic [57:0] LIN_HALF  = 58'd160000;
  localparam logic [57:0] QUAD_HALF = 58'd12500 << 25;
  localparam longint      LIN_K     = 625;
  localparam longint      QUAD_K    = 25000;
  localparam longint      LIN_M     = ((64'd1 << 40) + LIN_K - 1) / LIN_K;
  localparam longint      QUAD_M    = ((64'd1 << 45) + QUAD_K - 1) / QUAD_K;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef logic signed [22:0] wu_t;
  typedef logic signed [20:0] wt_t;

  typedef struct packed {
    logic        quad;
    logic [1:0]  i0;
    logic [3:0]  j0;
    wu_t [2:0]   wu;
    wt_t [2:0]   wt;
  } entry_t;

  function automatic logic [13:0] grid_at(input logic [2:0] row, input logic [4:0] col);
    logic [2:0] r;
    logic [3:0] c;
    r = (row > 3'd4) ? 3'd4 : row;
    c = (col > 5'd12) ? 4'd12 : col[3:0];
    return GRID_MIL[r][c];
  endfunction

endpackage

[rtl/core/l2ti_front.sv]
// front end: clamps inputs, finds the bracket and forms the Lagrange weights
`timescale 1ns / 1ps
module l2ti_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             quad_mode,
  input  logic [15:0]      view_secant,
  input  logic [15:0]      bright_temp,
  output logic             push,
  output l2ti_pkg::entry_t entry
);
  import l2ti_pkg::*;

  logic        vld_r, vld_nxt;
  logic        quad_r, quad_nxt;
  logic [1:0]  i0_r, i0_nxt;
  logic [3:0]  j0_r, j0_nxt;
  logic [11:0] du_r, du_nxt;
  logic [10:0] dt_r, dt_nxt;

  logic [15:0] u, t, du_w, dt_w;
  logic [2:0]  ib;
  logic [3:0]  jb;

  always_comb begin
    u = view_secant;
    if (u > SEC_HI) u = SEC_HI;
    if (u < SEC_LO) u = SEC_LO;
    t = bright_temp;
    if (t < TMP_LO) t = TMP_LO;
    if (t > TMP_HI) t = TMP_HI;

    if (u >= SEC_HI - SEC_STEP) ib = 3'd1;
    else if (u >= SEC_HI - 16'd2 * SEC_STEP) ib = 3'd2;
    else if (u >= SEC_HI - 16'd3 * SEC_STEP) ib = 3'd3;
    else ib = 3'd4;

    jb = 4'd12;
    for (int a = 12; a >= 1; a--) begin
      if (t <= TMP_LO + TMP_STEP * 16'(a)) jb = 4'(a);
    end

    i0_nxt = 2'(ib - 3'd1);
    j0_nxt = jb - 4'd1;
    if (quad_mode && ib == 3'd4) i0_nxt = 2'd2;
    if (quad_mode && jb == 4'd12) j0_nxt = 4'd10;

    du_w   = SEC_HI - SEC_STEP * {14'd0, i0_nxt} - u;
    dt_w   = t - TMP_LO - TMP_STEP * {12'd0, j0_nxt};
    du_nxt = du_w[11:0];
    dt_nxt = dt_w[10:0];
    quad_nxt = quad_mode;
    vld_nxt  = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    quad_r <= quad_nxt;
    i0_r   <= i0_nxt;
    j0_r   <= j0_nxt;
    du_r   <= du_nxt;
    dt_r   <= dt_nxt;
  end

  // weight lanes
  logic signed [13:0] ud, ua, ub;
  logic signed [12:0] td, ta, tb;
  logic signed [27:0] pu0, pu1, pu2;
  logic signed [25:0] pt0, pt1, pt2;

  always_comb begin
    ud = $signed({2'b0, du_r});
    ua = ud - 14'sd1024;
    ub = ud - 14'sd2048;
    td = $signed({2'b0, dt_r});
    ta = td - 13'sd640;
    tb = td - 13'sd1280;
    pu0 = ua * ub;
    pu1 = (ud * -ub) <<< 1;
    pu2 = ud * ua;
    pt0 = ta * tb;
    pt1 = (td * -tb) <<< 1;
    pt2 = td * ta;

    entry.quad = quad_r;
    entry.i0   = i0_r;
    entry.j0   = j0_r;
    if (quad_r) begin
      entry.wu[0] = pu0[22:0];
      entry.wu[1] = pu1[22:0];
      entry.wu[2] = pu2[22:0];
      entry.wt[0] = pt0[20:0];
      entry.wt[1] = pt1[20:0];
      entry.wt[2] = pt2[20:0];
    end else begin
      entry.wu[0] = 23'(-ua);
      entry.wu[1] = 23'(ud);
      entry.wu[2] = '0;
      entry.wt[0] = 21'(-ta);
      entry.wt[1] = 21'(td);
      entry.wt[2] = '0;
    end
    push = vld_r;
  end

endmodule

[rtl/core/l2ti_fifo.sv]
// short queue between front and back end
`timescale 1ns / 1ps
module l2ti_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  l2ti_pkg::entry_t            din,
  input  logic                        pop,
  output l2ti_pkg::entry_t            dout,
  output logic [l2ti_pkg::FIFO_AW:0]  count
);
  import l2ti_pkg::*;

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{FIFO_AW{1'b0}}, push} - {{FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem[wp_r] <= din;
  end

  assign dout  = mem[rp_r];
  assign count = cnt_r;

endmodule

[rtl/core/l2ti_back.sv]
// back end: table products, weighted sum, rounding division and saturation
`timescale 1ns / 1ps
module l2ti_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_in,
  input  l2ti_pkg::entry_t   entry,
  output logic               out_valid,
  output logic signed [15:0] out_threshold
);
  import l2ti_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic               q1_r, q2_r, q3_r, q4_r, q5_r;
  logic               n4_r, n5_r;
  logic signed [36:0] s_r [3];
  logic signed [36:0] s_nxt [3];
  wt_t [2:0]          wt_r;
  logic signed [37:0] ph_r [3];
  logic signed [37:0] ph_nxt [3];
  logic signed [41:0] pl_r [3];
  logic signed [41:0] pl_nxt [3];
  logic signed [57:0] num_r, num_nxt;
  logic [29:0]        x_r, x_nxt;
  logic [60:0]        prod_r, prod_nxt;
  logic signed [15:0] res_r, res_nxt;
  logic [57:0]        mag, rsum;
  logic [20:0]        quo;

  // row sums over the secant weights
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      s_nxt[b] = '0;
      for (int a = 0; a < 3; a++) begin
        s_nxt[b] = s_nxt[b]
          + $signed({1'b0, grid_at(3'({1'b0, entry.i0}) + 3'(a),
                                   5'({1'b0, entry.j0}) + 5'(b))})
          * $signed(entry.wu[a]);
      end
    end
  end

  // split products against the temperature weights
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      ph_nxt[b] = $signed(s_r[b][36:20]) * $signed(wt_r[b]);
      pl_nxt[b] = $signed({1'b0, s_r[b][19:0]}) * $signed(wt_r[b]);
    end
    num_nxt = '0;
    for (int b = 0; b < 3; b++) begin
      num_nxt = num_nxt + $signed({ph_r[b][37:0], 20'd0})
                + $signed({{16{pl_r[b][41]}}, pl_r[b]});
    end
  end

  // magnitude, half step and shift; then reciprocal multiply, sign restore and saturation
  always_comb begin
    mag   = num_r[57] ? 58'(-num_r) : 58'(num_r);
    rsum  = mag + (q3_r ? QUAD_HALF : LIN_HALF);
    x_nxt = q3_r ? rsum[54:25] : rsum[38:9];
    prod_nxt = 61'(x_r) * (q4_r ? 61'(QUAD_M) : 61'(LIN_M));
    quo = q5_r ? {5'd0, prod_r[60:45]} : prod_r[60:40];
    if (!n5_r) begin
      res_nxt = (quo > 21'd32767) ? 16'sh7fff : $signed(quo[15:0]);
    end else begin
      res_nxt = (quo > 21'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, quo[15:0]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    s_r    <= s_nxt;
    wt_r   <= entry.wt;
    q1_r   <= entry.quad;
    ph_r   <= ph_nxt;
    pl_r   <= pl_nxt;
    q2_r   <= q1_r;
    num_r  <= num_nxt;
    q3_r   <= q2_r;
    x_r    <= x_nxt;
    n4_r   <= num_r[57];
    q4_r   <= q3_r;
    prod_r <= prod_nxt;
    n5_r   <= n4_r;
    q5_r   <= q4_r;
    res_r  <= res_nxt;
  end

  assign out_valid     = v6_r;
  assign out_threshold = res_r;

endmodule

[rtl/core/lagrange_2d_table_interpolator_top.sv]
// top level of the 2-D Lagrange table interpolator
`timescale 1ns / 1ps
// usage
//   input: drive in_view_secant (Q4.12) and in_bright_temp (Q10.6) with start;
//   an item is taken at a clock edge where start is high and busy is low
//   result: out_threshold (signed Q5.11) is shown for one cycle with out_valid;
//   the receiver cannot hold results off and none are buffered for it
//   config: cfg_interp_mode (0 linear, 1 quadratic) written on cfg_valid,
//   cfg_ready is always high; write only while no item is in flight
//   path: each item goes through the front-end register, the queue and the back end
//   throughput: one item per cycle; the front end, the four-entry queue and
//   the six-stage back end all advance every cycle, the back end pops whenever
//   the queue is not empty, so the queue holds at most one item and busy stays low
//   the longest stages are the 30 x 31 reciprocal multiply and the 58-bit sum
//   reset: synchronous active-low rst_n empties the pipeline and queue and
//   sets linear mode; out_valid is low in the cycle after reset
module lagrange_2d_table_interpolator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_view_secant,
  input  logic [15:0]        in_bright_temp,
  output logic               out_valid,
  output logic signed [15:0] out_threshold,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_interp_mode
);
  import l2ti_pkg::*;

  logic               mode_r, mode_nxt;
  logic               push, pop;
  entry_t             f_entry, q_entry;
  logic [FIFO_AW:0]   count;

  assign cfg_ready = 1'b1;
  assign mode_nxt  = (cfg_valid && cfg_ready) ? cfg_interp_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // one item may still be in the front stage when the queue is judged
  assign busy = count >= (FIFO_AW + 1)'(2);
  assign pop  = count != '0;

  l2ti_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (start && !busy),
    .quad_mode   (mode_r),
    .view_secant (in_view_secant),
    .bright_temp (in_bright_temp),
    .push        (push),
    .entry       (f_entry)
  );

  l2ti_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (f_entry),
    .pop   (pop),
    .dout  (q_entry),
    .count (count)
  );

  l2ti_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .vld_in        (pop),
    .entry         (q_entry),
    .out_valid     (out_valid),
    .out_threshold (out_threshold)
  );

endmodule

[rtl/core/l2ti_checker.sv]
// port-level checker for the interpolator, bound to the top level
`timescale 1ns / 1ps
module l2ti_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("result missing 8 cycles after item");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 8))
    else $error("result without matching item");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && cfg_ready)
    else $error("block stalled");

endmodule

bind lagrange_2d_table_interpolator_top l2ti_checker u_l2ti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_ready (cfg_ready)
);

[verif/l2ti_checker.sv]
// checker for the 2-D Lagrange table interpolator: predicts thresholds and compares results
`timescale 1ns / 1ps
module l2ti_tb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [15:0]        in_view_secant,
  input  logic [15:0]        in_bright_temp,
  input  logic               out_valid,
  input  logic signed [15:0] out_threshold,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_interp_mode,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);
  import l2ti_pkg::*;

  logic             quad_mode;
  logic signed [15:0] threshold_q[$];

  function automatic void fill_weights(input logic quad, input longint d, input longint sp,
                                       output longint w[3]);
    if (!quad) begin
      w[0] = sp - d;
      w[1] = d;
      w[2] = 0;
    end else begin
      w[0] = (d - sp) * (d - 2 * sp);
      w[1] = 2 * d * (2 * sp - d);
      w[2] = d * (d - sp);
    end
  endfunction

  function automatic logic signed [15:0] predict_threshold(input logic quad,
                                                          input logic [15:0] sec,
                                                          input logic [15:0] tmp);
    longint u, t, num, den, q, r;
    longint wu[3], wt[3];
    int ib, jb, i0, j0, n;
    u = sec;
    t = tmp;
    if (u > SEC_HI) u = SEC_HI;
    if (u < SEC_LO) u = SEC_LO;
    if (t < TMP_LO) t = TMP_LO;
    if (t > TMP_HI) t = TMP_HI;
    ib = 4;
    jb = 12;
    for (int a = 4; a >= 1; a--) if (u >= SEC_HI - SEC_STEP * a) ib = a;
    for (int a = 12; a >= 1; a--) if (t <= TMP_LO + TMP_STEP * a) jb = a;
    i0 = ib - 1;
    j0 = jb - 1;
    if (quad && ib == 4) i0 = 2;
    if (quad && jb == 12) j0 = 10;
    fill_weights(quad, (SEC_HI - SEC_STEP * i0) - u, SEC_STEP, wu);
    fill_weights(quad, t - (TMP_LO + TMP_STEP * j0), TMP_STEP, wt);
    n = quad ? 3 : 2;
    num = 0;
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        num += longint'(GRID_MIL[i0 + a][j0 + b]) * wu[a] * wt[b];
    if (quad) begin
      q = num;
      den = 64'd1000 * 1024 * (2 * 640 * 640);
    end else begin
      q = num * 2;
      den = 64'd1000 * 640;
    end
    if (q >= 0) r = (q + den / 2) / den;
    else r = -((-q + den / 2) / den);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  assign pending = threshold_q.size();

  always @(posedge clk) begin
    logic signed [15:0] want;
    if (!rst_n) begin
      quad_mode <= 1'b0;
      threshold_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (out_valid) begin
        if (threshold_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %0d", out_threshold);
          fail_count <= fail_count + 1;
        end else begin
          want = threshold_q.pop_front();
          checked <= checked + 1;
          if (want !== out_threshold) begin
            if (fail_count < 10)
              $display("threshold mismatch: expected %0d got %0d", want, out_threshold);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) threshold_q.push_back(predict_threshold(quad_mode, in_view_secant,
                                                                  in_bright_temp));
      if (cfg_valid && cfg_ready) quad_mode <= cfg_interp_mode;
    end
  end

endmodule

[verif/tb_lagrange_2d_table_interpolator_top.sv]
// testbench top for the 2-D Lagrange table interpolator: stimulus and verdict
`timescale 1ns / 1ps
module tb_lagrange_2d_table_interpolator_top;
  import l2ti_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_view_secant = '0;
  logic [15:0] in_bright_temp = '0;
  logic out_valid;
  logic signed [15:0] out_threshold;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_interp_mode = 1'b0;
  int fail_count, pending, checked;
  int sent_lin, sent_quad;
  logic cur_mode;

  always #6 clk = ~clk;

  lagrange_2d_table_interpolator_top dut (.*);

  l2ti_tb_checker checker_i (.*);

  task automatic send_item(input logic [15:0] sec, input logic [15:0] tmp, input bit gaps);
    while (gaps && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_view_secant <= sec;
    in_bright_temp <= tmp;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cur_mode) sent_quad++;
    else sent_lin++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_interp_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_mode = m;
    @(posedge clk);
  endtask

  task automatic random_item(input bit gaps);
    logic [15:0] s, t;
    case ($urandom_range(9))
      0: s = 16'($urandom);
      1: s = 16'(SEC_LO + SEC_STEP * $urandom_range(4));
      default: s = 16'($urandom_range(8192 + 20, 4096 - 20));
    endcase
    case ($urandom_range(9))
      0: t = 16'($urandom);
      1: t = 16'(TMP_LO + TMP_STEP * $urandom_range(12));
      default: t = 16'($urandom_range(19840 + 30, 12160 - 30));
    endcase
    send_item(s, t, gaps);
  endtask

  task automatic directed_set();
    logic [15:0] secs[7] = '{16'd0, 16'd4096, 16'd5120, 16'd7000, 16'd8191, 16'd8192,
                             16'hFFFF};
    logic [15:0] tmps[4] = '{16'd0, 16'd12160, 16'd19840, 16'hFFFF};
    foreach (secs[a]) send_item(secs[a], tmps[a % 4], 1'b0);
    send_item(16'd7168, 16'd19200, 1'b0);
    send_item(16'd4500, 16'd19839, 1'b0);
    send_item(16'd6144, 16'd12800, 1'b0);
    send_item(16'h5555, 16'hAAAA, 1'b0);
    send_item(16'hAAAA, 16'h5555, 1'b0);
  endtask

  initial begin
    #30_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    cur_mode = 1'b0;
    sent_lin = 0;
    sent_quad = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_set();
    drain();
    set_mode(1'b1);
    directed_set();
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0]);
      for (int k = 0; k < 140; k++) random_item(ph != 2);
      drain();
    end
    drain();
    $display("covered %0d linear and %0d quadratic items, %0d results checked",
             sent_lin, sent_quad, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
